// ===== hdl/gmps_pkg.sv =====
// ----------------------------------------------------------------------------
// gmps_pkg
// Shared sizes, types and helpers for the grid minimum path sum block.
// ----------------------------------------------------------------------------
package gmps_pkg;

    localparam int MAX_ROWS  = 1024;
    localparam int MAX_COLS  = 1024;
    localparam int COST_BITS = 16;

    localparam int ROW_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_BITS  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SIZE_BITS = 11;
    localparam int SUM_BITS  = 27;

    localparam int IN_DATA_BITS  = 16;
    localparam int OUT_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    localparam logic [SIZE_BITS-1:0] ROWS_LIM = SIZE_BITS'(MAX_ROWS);
    localparam logic [SIZE_BITS-1:0] COLS_LIM = SIZE_BITS'(MAX_COLS);
    localparam logic [SUM_BITS-1:0]  SUM_MAX  = '1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROWS_IN_USE = 1'b0,
        REG_COLS_IN_USE = 1'b1
    } cfg_reg_t;

    // one classified cell on its way from front to back
    typedef struct packed {
        logic [COST_BITS-1:0] cost;
        logic [COL_BITS-1:0]  col;
        logic                 use_below;
        logic                 use_right;
        logic                 last_cell;
    } cell_item_t;

    // last index for a size register: zero counts as one, large values saturate
    function automatic logic [SIZE_BITS-1:0] size_last(
        input logic [SIZE_BITS-1:0] v,
        input logic [SIZE_BITS-1:0] lim
    );
        logic [SIZE_BITS-1:0] r;
        if (v == '0)
            r = '0;
        else if (v > lim)
            r = lim - SIZE_BITS'(1);
        else
            r = v - SIZE_BITS'(1);
        return r;
    endfunction

endpackage

// ===== hdl/gmps_front.sv =====
// ----------------------------------------------------------------------------
// gmps_front
// Holds grid sizes and the position walk; classifies each incoming cell.
// ----------------------------------------------------------------------------
module gmps_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [gmps_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [gmps_pkg::SIZE_BITS-1:0]        cfg_data,
    input  logic                                  in_valid,
    input  logic [gmps_pkg::COST_BITS-1:0]        in_cost,
    input  logic                                  q_full,
    output logic                                  in_ready,
    output logic                                  push,
    output gmps_pkg::cell_item_t                  push_item
);

    logic [gmps_pkg::ROW_BITS-1:0] last_row_reg, last_row_next;
    logic [gmps_pkg::COL_BITS-1:0] last_col_reg, last_col_next;
    logic [gmps_pkg::ROW_BITS-1:0] row_reg, row_next;
    logic [gmps_pkg::COL_BITS-1:0] col_reg, col_next;
    logic [gmps_pkg::SIZE_BITS-1:0] cfg_last;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_item.cost      = in_cost;
        push_item.col       = col_reg;
        push_item.use_below = (row_reg != last_row_reg);
        push_item.use_right = (col_reg != last_col_reg);
        push_item.last_cell = (row_reg == '0) && (col_reg == '0);
    end

    always_comb
    begin
        last_row_next = last_row_reg;
        last_col_next = last_col_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cfg_last      = '0;
        if (cfg_we)
        begin
            case (gmps_pkg::cfg_reg_t'(cfg_index))
                gmps_pkg::REG_ROWS_IN_USE:
                begin
                    cfg_last      = gmps_pkg::size_last(cfg_data, gmps_pkg::ROWS_LIM);
                    last_row_next = cfg_last[gmps_pkg::ROW_BITS-1:0];
                end
                gmps_pkg::REG_COLS_IN_USE:
                begin
                    cfg_last      = gmps_pkg::size_last(cfg_data, gmps_pkg::COLS_LIM);
                    last_col_next = cfg_last[gmps_pkg::COL_BITS-1:0];
                end
                default:
                begin
                    cfg_last = '0;
                end
            endcase
            // any write starts a fresh problem
            row_next = last_row_next;
            col_next = last_col_next;
        end
        else if (push)
        begin
            if (col_reg == '0)
            begin
                col_next = last_col_reg;
                row_next = (row_reg == '0) ? last_row_reg
                                           : row_reg - gmps_pkg::ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg - gmps_pkg::COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_row_reg <= '0;
            last_col_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            last_row_reg <= last_row_next;
            last_col_reg <= last_col_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

endmodule

// ===== hdl/gmps_queue.sv =====
// ----------------------------------------------------------------------------
// gmps_queue
// Short FIFO of classified cells between front and back.
// ----------------------------------------------------------------------------
module gmps_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  gmps_pkg::cell_item_t push_item,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output gmps_pkg::cell_item_t head
);

    gmps_pkg::cell_item_t slots_reg [gmps_pkg::QUEUE_DEPTH];
    logic [gmps_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gmps_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [gmps_pkg::QCNT_BITS-1:0] count_reg, count_next;

    assign full      = (count_reg == gmps_pkg::QCNT_BITS'(gmps_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + gmps_pkg::QCNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - gmps_pkg::QCNT_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/gmps_back.sv =====
// ----------------------------------------------------------------------------
// gmps_back
// Row buffer read, min/add of each cell and the result output register.
// ----------------------------------------------------------------------------
module gmps_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_not_empty,
    input  gmps_pkg::cell_item_t                 q_head,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [gmps_pkg::SUM_BITS-1:0]        out_sum
);

    logic [gmps_pkg::SUM_BITS-1:0] row_mem [gmps_pkg::MAX_COLS];

    gmps_pkg::cell_item_t          cell_reg;
    logic                          cell_valid_reg, cell_valid_next;
    logic [gmps_pkg::SUM_BITS-1:0] rd_data_reg;
    logic                          fwd_reg;
    logic [gmps_pkg::SUM_BITS-1:0] fwd_val_reg;
    logic [gmps_pkg::SUM_BITS-1:0] right_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [gmps_pkg::SUM_BITS-1:0] out_sum_reg;

    logic                          advance;
    logic [gmps_pkg::SUM_BITS-1:0] below;
    logic [gmps_pkg::SUM_BITS-1:0] m;
    logic [gmps_pkg::SUM_BITS:0]   raw;
    logic [gmps_pkg::SUM_BITS-1:0] best;

    assign advance = cell_valid_reg &&
                     (!cell_reg.last_cell || !out_valid_reg || out_ready);
    assign pop     = q_not_empty && (!cell_valid_reg || advance);

    // a write to the same column on the load edge is not seen by the read
    assign below = fwd_reg ? fwd_val_reg : rd_data_reg;

    always_comb
    begin
        if (cell_reg.use_below && cell_reg.use_right)
            m = (right_reg < below) ? right_reg : below;
        else if (cell_reg.use_below)
            m = below;
        else if (cell_reg.use_right)
            m = right_reg;
        else
            m = '0;
        raw  = {1'b0, m} + (gmps_pkg::SUM_BITS + 1)'(cell_reg.cost);
        best = raw[gmps_pkg::SUM_BITS] ? gmps_pkg::SUM_MAX : raw[gmps_pkg::SUM_BITS-1:0];
    end

    always_comb
    begin
        cell_valid_next = cell_valid_reg;
        if (pop)
            cell_valid_next = 1'b1;
        else if (advance)
            cell_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && cell_reg.last_cell)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            row_mem[cell_reg.col] <= best;
        if (pop)
        begin
            rd_data_reg <= row_mem[q_head.col];
            cell_reg    <= q_head;
            fwd_reg     <= advance && (cell_reg.col == q_head.col);
            fwd_val_reg <= best;
        end
        if (advance)
            right_reg <= best;
        if (advance && cell_reg.last_cell)
            out_sum_reg <= best;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cell_valid_reg <= cell_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;

endmodule

// ===== hdl/grid_min_path_sum.sv =====
// ----------------------------------------------------------------------------
// grid_min_path_sum
// Minimum grid path sum, moving only down or right, one cell a cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel   direction  transfer when            payload
//  s_axis    in         tvalid & tready          cell_cost, reverse raster order
//  m_axis    out        tvalid & tready          path_sum, once per grid
//  cfg       in         cfg_we                   rows_in_use (0), cols_in_use (1)
//
//  One cell per cycle sustained while no result cell waits on m_axis_tready;
//  the row buffer read and the min/add sit in separate stages. The last
//  cell goes from the queue to the cell register, its sum to out_sum_reg.
//  A full two-entry queue drops s_axis_tready; only the result cell
//  waits on m_axis_tready, other cells pass beneath a held result.
//  Reset is immediate: the row buffer needs no clearing pass, since a
//  column is always written by the row below before it is read.
// ----------------------------------------------------------------------------
module grid_min_path_sum (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration writes
    input  logic                                   cfg_we,
    input  logic [gmps_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [gmps_pkg::SIZE_BITS-1:0]         cfg_data,
    // cell stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [gmps_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,   // [15:0] cell_cost
    // result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [gmps_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata    // [26:0] path_sum, rest 0
);

    logic                          q_full;
    logic                          q_not_empty;
    logic                          push;
    logic                          pop;
    gmps_pkg::cell_item_t          push_item;
    gmps_pkg::cell_item_t          q_head;
    logic [gmps_pkg::SUM_BITS-1:0] path_sum;

    // front: sizes, position walk, neighbour flags
    gmps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_cost   (s_axis_tdata[gmps_pkg::COST_BITS-1:0]),
        .q_full    (q_full),
        .in_ready  (s_axis_tready),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    gmps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back: row buffer, min/add, result register
    gmps_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_sum     (path_sum)
    );

    assign m_axis_tdata = gmps_pkg::OUT_DATA_BITS'(path_sum);

endmodule

// ===== hdl/gmps_checker.sv =====
// ----------------------------------------------------------------------------
// gmps_checker
// Port-level assertions for grid_min_path_sum, bound to the top level.
// ----------------------------------------------------------------------------
module gmps_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    input  logic                                   s_axis_tready,
    input  logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic [gmps_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // queue is empty as reset lifts
    a_ready_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> s_axis_tready)
        else $error("input not ready after reset");

    // the queue only fills through a transfer
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("ready dropped without a transfer");

    // padding above path_sum stays clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[gmps_pkg::OUT_DATA_BITS-1:gmps_pkg::SUM_BITS] == '0))
        else $error("non-zero padding in result");

endmodule

bind grid_min_path_sum gmps_checker u_gmps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grid_min_path_sum.
// Feeds grids of cell costs in reverse raster order under random sender gaps
// and receiver stalls, predicts each path_sum with a cycle-free model of the
// row-by-row DP, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 4000;  // cycles with no transfer or register write
    localparam int DRAIN_CYCLES = 8;     // margin for the queue, cell and result registers
    localparam int CELL_TARGET  = 1500;

    // receiver stall modes
    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

    // ------------------------------------------------------------------------
    // Path sum predictor and result store
    // ------------------------------------------------------------------------
    class path_sum_board;
        int unsigned                    errors;
        logic [gmps_pkg::SUM_BITS-1:0]  expected_sums[$];
        logic [gmps_pkg::SIZE_BITS-1:0] rows_reg;
        logic [gmps_pkg::SIZE_BITS-1:0] cols_reg;
        logic [gmps_pkg::SUM_BITS-1:0]  below_sums[gmps_pkg::MAX_COLS];
        logic [gmps_pkg::SUM_BITS-1:0]  right_best;
        int                             row_at;
        int                             col_at;

        function new();
            errors   = 0;
            rows_reg = gmps_pkg::SIZE_BITS'(1);
            cols_reg = gmps_pkg::SIZE_BITS'(1);
            foreach (below_sums[i])
                below_sums[i] = '0;
            restart_grid();
        endfunction

        // zero reads as one, oversize saturates
        function int last_index(logic [gmps_pkg::SIZE_BITS-1:0] v, int lim);
            if (v == '0)
                return 0;
            if (int'(v) > lim)
                return lim - 1;
            return int'(v) - 1;
        endfunction

        function void restart_grid();
            right_best = '0;
            row_at     = last_index(rows_reg, gmps_pkg::MAX_ROWS);
            col_at     = last_index(cols_reg, gmps_pkg::MAX_COLS);
        endfunction

        // any write drops the grid in progress
        function void write_reg(gmps_pkg::cfg_reg_t idx,
                                logic [gmps_pkg::SIZE_BITS-1:0] value);
            case (idx)
                gmps_pkg::REG_ROWS_IN_USE: rows_reg = value;
                gmps_pkg::REG_COLS_IN_USE: cols_reg = value;
                default: ;
            endcase
            restart_grid();
        endfunction

        function void note_cell(logic [gmps_pkg::COST_BITS-1:0] cost);
            int                          lr;
            int                          lc;
            int                          r;
            int                          c;
            bit                          have;
            logic [gmps_pkg::SUM_BITS:0] m;
            logic [gmps_pkg::SUM_BITS:0] best;
            lr   = last_index(rows_reg, gmps_pkg::MAX_ROWS);
            lc   = last_index(cols_reg, gmps_pkg::MAX_COLS);
            r    = (row_at > lr) ? lr : row_at;
            c    = (col_at > lc) ? lc : col_at;
            have = 1'b0;
            m    = '0;
            if (r < lr)
            begin
                m    = below_sums[c];
                have = 1'b1;
            end
            if (c < lc && (!have || right_best < m))
                m = right_best;
            best = m + cost;
            if (best > gmps_pkg::SUM_MAX)
                best = gmps_pkg::SUM_MAX;
            below_sums[c] = best[gmps_pkg::SUM_BITS-1:0];
            right_best    = best[gmps_pkg::SUM_BITS-1:0];
            if (c == 0)
            begin
                if (r == 0)
                begin
                    expected_sums.push_back(best[gmps_pkg::SUM_BITS-1:0]);
                    restart_grid();
                end
                else
                begin
                    row_at     = r - 1;
                    col_at     = lc;
                    right_best = '0;
                end
            end
            else
            begin
                row_at = r;
                col_at = c - 1;
            end
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: path_sum error: %s", $time, what);
            errors++;
        endtask

        task check_sum(logic [gmps_pkg::OUT_DATA_BITS-1:0] data);
            logic [gmps_pkg::SUM_BITS-1:0] want;
            if (expected_sums.size() == 0)
            begin
                report_mismatch($sformatf("result 0x%08h with no grid outstanding", data));
                return;
            end
            want = expected_sums.pop_front();
            if (data[gmps_pkg::SUM_BITS-1:0] != want)
                report_mismatch($sformatf("got %0d, want %0d",
                                          data[gmps_pkg::SUM_BITS-1:0], want));
            if (data[gmps_pkg::OUT_DATA_BITS-1:gmps_pkg::SUM_BITS] != '0)
                report_mismatch($sformatf("pad bits set in 0x%08h", data));
        endtask

        task check_drained();
            if (expected_sums.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", expected_sums.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and clock
    // ------------------------------------------------------------------------
    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  cfg_we;
    logic [gmps_pkg::CFG_IDX_BITS-1:0]     cfg_index;
    logic [gmps_pkg::SIZE_BITS-1:0]        cfg_data;
    logic                                  s_axis_tvalid;
    logic                                  s_axis_tready;
    logic [gmps_pkg::IN_DATA_BITS-1:0]     s_axis_tdata;   // [15:0] cell_cost
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready;
    logic [gmps_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata;   // [26:0] path_sum, rest 0

    always #1 clk = ~clk;

    grid_min_path_sum uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    path_sum_board board;
    int unsigned   cells_taken;
    int unsigned   stall_cycles;
    int            burst_left;

    // ------------------------------------------------------------------------
    // Monitor: values read here are the ones before the edge, so both
    // transfers are seen exactly as the DUT saw them.
    // Results are checked before the cell of the same edge is noted; a
    // result can never belong to a cell taken at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_sum(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
            begin
                board.note_cell(s_axis_tdata[gmps_pkg::COST_BITS-1:0]);
                cells_taken++;
            end
        end
    end

    // Watchdog: any transfer or register write counts as progress
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern switches between free running, coin toss,
    // mostly stalled and solid hold-offs.
    // ------------------------------------------------------------------------
    rx_mode_t rx_mode = RX_FREE;
    int       rx_left = 0;

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(20, 300);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default:   m_axis_tready <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Register write; only called with the block idle
    task write_reg(input gmps_pkg::cfg_reg_t idx,
                   input logic [gmps_pkg::SIZE_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        board.write_reg(idx, value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One cell transfer; the sender runs in bursts with random gaps
    task send_cell(input logic [gmps_pkg::COST_BITS-1:0] cost);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cost;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted sum has come back,
    // plus the pipeline depth, since cells that end no grid leave no trace.
    task drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Costs lean on zero, all-ones and small values
    function automatic logic [gmps_pkg::COST_BITS-1:0] pick_cost();
        int k;
        k = $urandom_range(0, 19);
        if (k < 3)
            return '0;
        if (k < 6)
            return '1;
        if (k < 8)
            return gmps_pkg::COST_BITS'($urandom_range(0, 15));
        return gmps_pkg::COST_BITS'($urandom);
    endfunction

    // One random phase: new sizes, whole grids, maybe a grid left unfinished.
    // Oversize grids are only ever started, never finished, except the single
    // wide grid that reaches the top column of the row buffer.
    task run_phase(input bit wide);
        int  rows_v;
        int  cols_v;
        int  bucket;
        int  grid_cells;
        int  grids;
        int  partial;
        bit  huge;
        bucket = $urandom_range(0, 99);
        huge   = 1'b0;
        if (wide)
        begin
            rows_v = 1;
            cols_v = 2047;
        end
        else if (bucket < 65)
        begin
            rows_v = $urandom_range(1, 6);
            cols_v = $urandom_range(1, 6);
        end
        else if (bucket < 76)
        begin
            rows_v = $urandom_range(1, 3);
            cols_v = $urandom_range(7, 48);
        end
        else if (bucket < 86)
        begin
            rows_v = $urandom_range(7, 40);
            cols_v = $urandom_range(1, 3);
        end
        else if (bucket < 94)
        begin
            rows_v = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
            cols_v = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
        end
        else
        begin
            huge   = 1'b1;
            rows_v = $urandom_range(1024, 2047);
            cols_v = $urandom_range(0, 1) ? $urandom_range(1024, 2047) : $urandom_range(0, 2);
        end

        if ($urandom_range(0, 1))
        begin
            write_reg(gmps_pkg::REG_ROWS_IN_USE, gmps_pkg::SIZE_BITS'(rows_v));
            write_reg(gmps_pkg::REG_COLS_IN_USE, gmps_pkg::SIZE_BITS'(cols_v));
        end
        else
        begin
            write_reg(gmps_pkg::REG_COLS_IN_USE, gmps_pkg::SIZE_BITS'(cols_v));
            write_reg(gmps_pkg::REG_ROWS_IN_USE, gmps_pkg::SIZE_BITS'(rows_v));
        end

        grid_cells = (board.last_index(gmps_pkg::SIZE_BITS'(rows_v), gmps_pkg::MAX_ROWS) + 1)
                   * (board.last_index(gmps_pkg::SIZE_BITS'(cols_v), gmps_pkg::MAX_COLS) + 1);
        grids   = huge ? 0 : (wide ? 1 : $urandom_range(1, 4));
        partial = 0;
        if (huge)
            partial = $urandom_range(1, 60);
        else if (grid_cells > 1 && $urandom_range(0, 9) < 3)
            partial = $urandom_range(1, grid_cells - 1);

        repeat (grids)
            repeat (grid_cells)
                send_cell(pick_cost());
        // an unfinished grid is abandoned by the next register write
        repeat (partial)
            send_cell(pick_cost());
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int phase_no;
        board         = new();
        cells_taken   = 0;
        burst_left    = 0;
        phase_no      = 0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= gmps_pkg::REG_ROWS_IN_USE;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // single-cell grid straight out of reset: each cost is its own sum
        send_cell('0);
        send_cell('1);
        send_cell(16'h5555);
        send_cell(16'hAAAA);
        drain_results();

        // zero sizes read as one
        write_reg(gmps_pkg::REG_ROWS_IN_USE, '0);
        write_reg(gmps_pkg::REG_COLS_IN_USE, '0);
        send_cell(16'h04D2);
        drain_results();

        // 2x3 grid started, then a write abandons it and it is redone
        write_reg(gmps_pkg::REG_ROWS_IN_USE, gmps_pkg::SIZE_BITS'(2));
        write_reg(gmps_pkg::REG_COLS_IN_USE, gmps_pkg::SIZE_BITS'(3));
        send_cell(16'd7);
        send_cell(16'd9);
        send_cell(16'd3);
        drain_results();
        write_reg(gmps_pkg::REG_COLS_IN_USE, gmps_pkg::SIZE_BITS'(3));
        send_cell('1);
        send_cell('0);
        send_cell('1);
        send_cell(16'd1);
        send_cell(16'd2);
        send_cell('1);
        drain_results();

        // 3x2 grid
        write_reg(gmps_pkg::REG_ROWS_IN_USE, gmps_pkg::SIZE_BITS'(3));
        write_reg(gmps_pkg::REG_COLS_IN_USE, gmps_pkg::SIZE_BITS'(2));
        send_cell(16'd100);
        send_cell(16'd1);
        send_cell('1);
        send_cell(16'd5);
        send_cell(16'd0);
        send_cell(16'd40);
        drain_results();

        // oversize registers saturate; this grid is left unfinished
        write_reg(gmps_pkg::REG_ROWS_IN_USE, '1);
        write_reg(gmps_pkg::REG_COLS_IN_USE, gmps_pkg::SIZE_BITS'(1025));
        repeat (4)
            send_cell(pick_cost());
        drain_results();

        // random phases; the fifth one is the full-width single-row grid
        while (cells_taken < CELL_TARGET || phase_no < 5)
        begin
            run_phase(phase_no == 4);
            phase_no++;
        end

        drain_results();
        board.check_drained();
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
